@@ rtl/bll_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bll_pkg
// Shared sizes, codes and node store port types of the linked list engine.
// ----------------------------------------------------------------------------
package bll_pkg;

  localparam int DEPTH       = 16;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int PTR_W       = $clog2(DEPTH + 1);
  localparam int VAL_W       = 32;
  localparam int POS_W       = 8;
  localparam int LEN_W       = 5;
  localparam int ST_W        = 2;
  localparam int TYPE_W      = 3;
  localparam int MAX_RESULTS = 16;
  localparam int DUMP_MAX    = (DEPTH < MAX_RESULTS) ? DEPTH : MAX_RESULTS;
  localparam int K_W         = $clog2(DUMP_MAX);

  localparam logic [PTR_W-1:0] NIL = PTR_W'(DEPTH);

  localparam logic [TYPE_W-1:0] REQ_HEAD = 3'd0;
  localparam logic [TYPE_W-1:0] REQ_TAIL = 3'd1;
  localparam logic [TYPE_W-1:0] REQ_POS  = 3'd2;
  localparam logic [TYPE_W-1:0] REQ_DEL  = 3'd3;
  localparam logic [TYPE_W-1:0] REQ_DUMP = 3'd4;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BADPOS   = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             val_we;
    logic [IDX_W-1:0] val_addr;
    logic [VAL_W-1:0] val_data;
    logic             lnk_we;
    logic [IDX_W-1:0] lnk_addr;
    logic [PTR_W-1:0] lnk_data;
  } mem_req_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [PTR_W-1:0] link;
  } mem_rsp_t;

endpackage
`default_nettype wire

@@ rtl/bounded_linked_list_engine.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_linked_list_engine
// Ordered list of up to DEPTH signed values kept in a linked node store.
// ----------------------------------------------------------------------------
// One request is handled at a time. After reset a clearing pass builds the
// free chain in the link memory; req_stall stays high meanwhile. A walk
// advances one node per cycle through the single read port of the node
// store; a dump walk waits while its result is stalled. Insert at head needs
// no walk, insert at tail walks the list, insert at position walks to the
// position, delete walks to the match, and dump walks the elements it returns.
// The result register frees the input side while the last result still
// waits to be taken.
module bounded_linked_list_engine (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              req_valid,
  output logic                                   req_stall,
  input  wire logic [bll_pkg::TYPE_W-1:0]        req_type,
  input  wire logic signed [bll_pkg::VAL_W-1:0]  value,
  input  wire logic [bll_pkg::POS_W-1:0]         position,
  output logic                                   rsp_valid,
  input  wire logic                              rsp_stall,
  output logic [bll_pkg::ST_W-1:0]               status,
  output logic signed [bll_pkg::VAL_W-1:0]       element,
  output logic [bll_pkg::LEN_W-1:0]              length,
  output logic                                   last
);
  import bll_pkg::*;

  mem_req_t mreq;
  mem_rsp_t mrsp;

  bll_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_type  (req_type),
    .value     (value),
    .position  (position),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .status    (status),
    .element   (element),
    .length    (length),
    .last      (last),
    .mreq      (mreq),
    .mrsp      (mrsp)
  );

  bll_mem u_mem (
    .clk  (clk),
    .mreq (mreq),
    .mrsp (mrsp)
  );

endmodule
`default_nettype wire

@@ rtl/bll_mem.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bll_mem
// Node store: value and next link memories, one write port each and a shared
// registered read port whose data appears in the cycle after rd_en.
// ----------------------------------------------------------------------------
module bll_mem (
  input  wire logic              clk,
  input  wire bll_pkg::mem_req_t mreq,
  output bll_pkg::mem_rsp_t      mrsp
);
  import bll_pkg::*;

  logic [VAL_W-1:0] val_mem [DEPTH];
  logic [PTR_W-1:0] lnk_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (mreq.val_we) begin
      val_mem[mreq.val_addr] <= mreq.val_data;
    end
    if (mreq.lnk_we) begin
      lnk_mem[mreq.lnk_addr] <= mreq.lnk_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mreq.rd_en) begin
      mrsp.value <= val_mem[mreq.rd_addr];
      mrsp.link  <= lnk_mem[mreq.rd_addr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/bll_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bll_ctrl
// Request sequencer: walks the node store one link per cycle when unstalled,
// keeps head, free chain and count, and drives the result register.
// ----------------------------------------------------------------------------
module bll_ctrl (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              req_valid,
  output logic                                   req_stall,
  input  wire logic [bll_pkg::TYPE_W-1:0]        req_type,
  input  wire logic signed [bll_pkg::VAL_W-1:0]  value,
  input  wire logic [bll_pkg::POS_W-1:0]         position,
  output logic                                   rsp_valid,
  input  wire logic                              rsp_stall,
  output logic [bll_pkg::ST_W-1:0]               status,
  output logic signed [bll_pkg::VAL_W-1:0]       element,
  output logic [bll_pkg::LEN_W-1:0]              length,
  output logic                                   last,
  output bll_pkg::mem_req_t                      mreq,
  input  wire bll_pkg::mem_rsp_t                 mrsp
);
  import bll_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_START, S_ALLOC, S_TWALK, S_PWALK, S_PLINK,
    S_DWALK, S_DFREE, S_DUMP, S_RESP
  } state_t;

  state_t                    state;
  logic [IDX_W-1:0]          clr_idx;
  logic [PTR_W-1:0]          head;
  logic [PTR_W-1:0]          free;
  logic [PTR_W-1:0]          count;
  logic [PTR_W-1:0]          cur;
  logic [PTR_W-1:0]          prev;
  logic [PTR_W-1:0]          node;
  logic [POS_W-1:0]          remain;
  logic [K_W-1:0]            k;
  logic [TYPE_W-1:0]         req_r;
  logic signed [VAL_W-1:0]   val_r;
  logic [POS_W-1:0]          pos_r;
  status_t                   st;

  logic full;
  logic bad_pos;
  logic at_head;
  logic out_free;
  logic dump_last;

  assign full      = (free == NIL) || (count >= PTR_W'(DEPTH));
  assign bad_pos   = (head != NIL) && ((pos_r == '0) || (pos_r > POS_W'(count)));
  assign at_head   = (req_r == REQ_HEAD) ||
                     ((req_r == REQ_POS) && ((head == NIL) || (pos_r == POS_W'(1))));
  assign out_free  = !rsp_valid || !rsp_stall;
  assign dump_last = (mrsp.link == NIL) || (k == K_W'(DUMP_MAX - 1));
  assign req_stall = (state != S_IDLE);

  // node store accesses
  always_comb begin
    mreq = '0;
    case (state)
      S_CLEAR: begin
        mreq.lnk_we   = 1'b1;
        mreq.lnk_addr = clr_idx;
        mreq.lnk_data = PTR_W'(clr_idx) + PTR_W'(1);
      end
      S_START: begin
        if (req_r inside {REQ_HEAD, REQ_TAIL, REQ_POS}) begin
          mreq.rd_en   = !full && !((req_r == REQ_POS) && bad_pos);
          mreq.rd_addr = free[IDX_W-1:0];
        end else if (req_r inside {REQ_DEL, REQ_DUMP}) begin
          mreq.rd_en   = (head != NIL);
          mreq.rd_addr = head[IDX_W-1:0];
        end
      end
      S_ALLOC: begin
        mreq.val_we   = 1'b1;
        mreq.val_addr = free[IDX_W-1:0];
        mreq.val_data = val_r;
        mreq.lnk_addr = free[IDX_W-1:0];
        if (at_head) begin
          mreq.lnk_we   = 1'b1;
          mreq.lnk_data = head;
        end else if (req_r == REQ_TAIL) begin
          mreq.lnk_we   = 1'b1;
          mreq.lnk_data = NIL;
          mreq.rd_en    = (head != NIL);
          mreq.rd_addr  = head[IDX_W-1:0];
        end else begin
          mreq.rd_en   = 1'b1;
          mreq.rd_addr = head[IDX_W-1:0];
        end
      end
      S_TWALK: begin
        if (mrsp.link == NIL) begin
          mreq.lnk_we   = 1'b1;
          mreq.lnk_addr = cur[IDX_W-1:0];
          mreq.lnk_data = node;
        end else begin
          mreq.rd_en   = 1'b1;
          mreq.rd_addr = mrsp.link[IDX_W-1:0];
        end
      end
      S_PWALK: begin
        if (remain == '0) begin
          mreq.lnk_we   = 1'b1;
          mreq.lnk_addr = node[IDX_W-1:0];
          mreq.lnk_data = mrsp.link;
        end else begin
          mreq.rd_en   = 1'b1;
          mreq.rd_addr = mrsp.link[IDX_W-1:0];
        end
      end
      S_PLINK: begin
        mreq.lnk_we   = 1'b1;
        mreq.lnk_addr = cur[IDX_W-1:0];
        mreq.lnk_data = node;
      end
      S_DWALK: begin
        if (mrsp.value == val_r) begin
          mreq.lnk_we   = (prev != NIL);
          mreq.lnk_addr = prev[IDX_W-1:0];
          mreq.lnk_data = mrsp.link;
        end else if (mrsp.link != NIL) begin
          mreq.rd_en   = 1'b1;
          mreq.rd_addr = mrsp.link[IDX_W-1:0];
        end
      end
      S_DFREE: begin
        mreq.lnk_we   = 1'b1;
        mreq.lnk_addr = cur[IDX_W-1:0];
        mreq.lnk_data = free;
      end
      S_DUMP: begin
        mreq.rd_en   = out_free && !dump_last;
        mreq.rd_addr = mrsp.link[IDX_W-1:0];
      end
      default: begin
        mreq = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      head      <= NIL;
      free      <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && (state != S_DUMP) && (state != S_RESP)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + IDX_W'(1);
          if (clr_idx == IDX_W'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            req_r <= req_type;
            val_r <= value;
            pos_r <= position;
            state <= S_START;
          end
        end
        S_START: begin
          st    <= ST_OK;
          state <= S_RESP;
          if (req_r inside {REQ_HEAD, REQ_TAIL, REQ_POS}) begin
            if (full) begin
              st <= ST_FULL;
            end else if ((req_r == REQ_POS) && bad_pos) begin
              st <= ST_BADPOS;
            end else begin
              state <= S_ALLOC;
            end
          end else if (req_r == REQ_DEL) begin
            if (head == NIL) begin
              st <= ST_NOTFOUND;
            end else begin
              cur   <= head;
              prev  <= NIL;
              state <= S_DWALK;
            end
          end else if (req_r == REQ_DUMP) begin
            if (head != NIL) begin
              k     <= '0;
              state <= S_DUMP;
            end
          end
        end
        S_ALLOC: begin
          node <= free;
          free <= mrsp.link;
          cur  <= head;
          if (at_head || ((req_r == REQ_TAIL) && (head == NIL))) begin
            head  <= free;
            count <= count + PTR_W'(1);
            state <= S_RESP;
          end else if (req_r == REQ_TAIL) begin
            state <= S_TWALK;
          end else begin
            remain <= pos_r - POS_W'(2);
            state  <= S_PWALK;
          end
        end
        S_TWALK: begin
          if (mrsp.link == NIL) begin
            count <= count + PTR_W'(1);
            state <= S_RESP;
          end else begin
            cur <= mrsp.link;
          end
        end
        S_PWALK: begin
          if (remain == '0) begin
            state <= S_PLINK;
          end else begin
            cur    <= mrsp.link;
            remain <= remain - POS_W'(1);
          end
        end
        S_PLINK: begin
          count <= count + PTR_W'(1);
          state <= S_RESP;
        end
        S_DWALK: begin
          if (mrsp.value == val_r) begin
            if (prev == NIL) begin
              head <= mrsp.link;
            end
            state <= S_DFREE;
          end else if (mrsp.link == NIL) begin
            st    <= ST_NOTFOUND;
            state <= S_RESP;
          end else begin
            prev <= cur;
            cur  <= mrsp.link;
          end
        end
        S_DFREE: begin
          free <= cur;
          if (count != '0) begin
            count <= count - PTR_W'(1);
          end
          st    <= ST_OK;
          state <= S_RESP;
        end
        S_DUMP: begin
          if (out_free) begin
            rsp_valid <= 1'b1;
            status    <= ST_OK;
            element   <= mrsp.value;
            length    <= LEN_W'(count);
            last      <= dump_last;
            k         <= k + K_W'(1);
            if (dump_last) begin
              state <= S_IDLE;
            end
          end
        end
        S_RESP: begin
          if (out_free) begin
            rsp_valid <= 1'b1;
            status    <= st;
            element   <= '0;
            length    <= LEN_W'(count);
            last      <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/bll_chk.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bll_chk
// Port level checks of the linked list engine, bound to the top level.
// ----------------------------------------------------------------------------
module bll_chk (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              req_valid,
  input  wire logic                              req_stall,
  input  wire logic                              rsp_valid,
  input  wire logic                              rsp_stall,
  input  wire logic [bll_pkg::ST_W-1:0]          status,
  input  wire logic signed [bll_pkg::VAL_W-1:0]  element,
  input  wire logic [bll_pkg::LEN_W-1:0]         length,
  input  wire logic                              last
);
  import bll_pkg::*;

  // clearing pass holds off requests right after reset
  a_clear_stall: assert property (@(posedge clk) rst |=> req_stall && !rsp_valid)
    else $error("request taken or result shown during clearing pass");

  // one request in flight
  a_one_at_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("second request taken in the cycle after a transfer");

  // error results are single and carry no element
  a_err_single: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status != ST_OK) |-> last && (element == '0))
    else $error("error result not final or with element");

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(status) && $stable(element) &&
    $stable(length) && $stable(last))
    else $error("stalled result changed");

endmodule

bind bounded_linked_list_engine bll_chk u_bll_chk (.*);
`default_nettype wire

@@ tb/sv/tb_bounded_linked_list_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bounded_linked_list_engine
// Self-checking bench for the bounded linked list engine. A queue of list
// requests (directed corner cases, then random grow, shrink and mixed runs
// over small value pools) feeds a clocked driver with random gaps. Every
// accepted request updates a shadow list that predicts the results, and a
// clocked monitor with random stalls checks each result field by field.
// ----------------------------------------------------------------------------
module tb_bounded_linked_list_engine;
  import bll_pkg::*;

  localparam logic [TYPE_W-1:0] REQ_SPARE_LO = REQ_DUMP + 3'd1;
  localparam logic [TYPE_W-1:0] REQ_SPARE_HI = '1;

  typedef struct {
    logic [TYPE_W-1:0] kind;
    logic [VAL_W-1:0]  val;
    logic [POS_W-1:0]  pos;
  } list_req_t;

  typedef struct {
    logic [ST_W-1:0]  st;
    logic [VAL_W-1:0] elem;
    logic [LEN_W-1:0] len;
    logic             lst;
  } list_rsp_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     req_valid = 1'b0;
  logic                     req_stall;
  logic [TYPE_W-1:0]        req_type = '0;
  logic signed [VAL_W-1:0]  value = '0;
  logic [POS_W-1:0]         position = '0;
  logic                     rsp_valid;
  logic                     rsp_stall = 1'b0;
  logic [ST_W-1:0]          status;
  logic signed [VAL_W-1:0]  element;
  logic [LEN_W-1:0]         length;
  logic                     last;

  bounded_linked_list_engine u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_type  (req_type),
    .value     (value),
    .position  (position),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .status    (status),
    .element   (element),
    .length    (length),
    .last      (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the node store
  logic [VAL_W-1:0] shadow_val  [DEPTH];
  logic [PTR_W-1:0] shadow_link [DEPTH];
  logic [PTR_W-1:0] shadow_head;
  logic [PTR_W-1:0] shadow_free;
  logic [LEN_W-1:0] shadow_count;

  list_req_t list_ops_q[$];
  list_rsp_t list_results_q[$];
  list_req_t drv_item;
  int        fail_cnt = 0;
  int        gap_left = 0;
  int        drv_calm = 0;
  int        stall_left = 0;
  int        mon_calm = 0;

  function automatic int idle_len(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm = $urandom_range(15, 40);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void push_result(logic [ST_W-1:0] st, logic [VAL_W-1:0] elem,
                                      logic lst);
    list_rsp_t rs;
    rs.st   = st;
    rs.elem = elem;
    rs.len  = shadow_count;
    rs.lst  = lst;
    list_results_q.push_back(rs);
  endfunction

  function automatic void list_apply(list_req_t rq);
    logic [PTR_W-1:0] n;
    logic [PTR_W-1:0] cur;
    logic [PTR_W-1:0] prv;
    int               i;
    int               k;
    case (rq.kind)
      REQ_HEAD, REQ_TAIL, REQ_POS: begin
        if (shadow_free == NIL || shadow_count >= DEPTH) begin
          push_result(ST_FULL, '0, 1'b1);
        end else if (rq.kind == REQ_POS && shadow_head != NIL &&
                     (rq.pos == 0 || rq.pos > shadow_count)) begin
          push_result(ST_BADPOS, '0, 1'b1);
        end else begin
          n = shadow_free;
          shadow_free = shadow_link[n];
          shadow_val[n] = rq.val;
          shadow_link[n] = NIL;
          if (rq.kind == REQ_HEAD || shadow_head == NIL ||
              (rq.kind == REQ_POS && rq.pos == 1)) begin
            shadow_link[n] = shadow_head;
            shadow_head = n;
          end else if (rq.kind == REQ_TAIL) begin
            cur = shadow_head;
            for (i = 0; i < DEPTH && shadow_link[cur] != NIL; i++) cur = shadow_link[cur];
            shadow_link[cur] = n;
          end else begin
            prv = shadow_head;
            for (i = 2; i < rq.pos && i <= DEPTH; i++) prv = shadow_link[prv];
            shadow_link[n] = shadow_link[prv];
            shadow_link[prv] = n;
          end
          shadow_count++;
          push_result(ST_OK, '0, 1'b1);
        end
      end
      REQ_DEL: begin
        prv = NIL;
        cur = shadow_head;
        for (i = 0; i < DEPTH && cur != NIL && shadow_val[cur] != rq.val; i++) begin
          prv = cur;
          cur = shadow_link[cur];
        end
        if (cur == NIL) begin
          push_result(ST_NOTFOUND, '0, 1'b1);
        end else begin
          if (prv == NIL) shadow_head = shadow_link[cur];
          else shadow_link[prv] = shadow_link[cur];
          shadow_link[cur] = shadow_free;
          shadow_free = cur;
          if (shadow_count > 0) shadow_count--;
          push_result(ST_OK, '0, 1'b1);
        end
      end
      REQ_DUMP: begin
        if (shadow_head == NIL) begin
          push_result(ST_OK, '0, 1'b1);
        end else begin
          cur = shadow_head;
          for (k = 0; k < DUMP_MAX && cur != NIL; k++) begin
            push_result(ST_OK, shadow_val[cur],
                        shadow_link[cur] == NIL || k + 1 == DUMP_MAX);
            cur = shadow_link[cur];
          end
        end
      end
      default: push_result(ST_OK, '0, 1'b1);
    endcase
  endfunction

  task automatic add_op(logic [TYPE_W-1:0] kind, logic [VAL_W-1:0] val,
                        logic [POS_W-1:0] pos);
    list_req_t rq;
    rq.kind = kind;
    rq.val  = val;
    rq.pos  = pos;
    list_ops_q.push_back(rq);
  endtask

  always @(posedge clk) begin : req_driver
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_stall === 1'b0) list_apply(drv_item);
      if (!req_valid || req_stall === 1'b0) begin
        if (gap_left > 0) begin
          gap_left--;
          req_valid <= 1'b0;
        end else if (list_ops_q.size() > 0) begin
          drv_item = list_ops_q.pop_front();
          req_type <= drv_item.kind;
          value <= drv_item.val;
          position <= drv_item.pos;
          req_valid <= 1'b1;
          gap_left = idle_len(drv_calm);
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : rsp_monitor
    list_rsp_t want;
    int        n;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid === 1'b1 && !rsp_stall) begin
        if (list_results_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("unexpected transfer: status %0d element %0d length %0d last %0b",
                     status, element, length, last);
        end else begin
          want = list_results_q.pop_front();
          if (status !== want.st || element !== want.elem ||
              length !== want.len || last !== want.lst) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display("mismatch: exp %0d %0d %0d %0b, got %0d %0d %0d %0b",
                       want.st, $signed(want.elem), want.len, want.lst,
                       status, element, length, last);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_stall <= 1'b1;
      end else begin
        n = idle_len(mon_calm);
        stall_left = (n > 0) ? n - 1 : 0;
        rsp_stall <= (n > 0);
      end
    end
  end

  initial begin : stimulus
    logic [VAL_W-1:0] pool [8];
    logic [VAL_W-1:0] v;
    logic [POS_W-1:0] p;
    logic [TYPE_W-1:0] kind;
    int c;
    int j;
    int r;
    int mode;
    int ins_w;
    int del_w;

    for (j = 0; j < DEPTH; j++) begin
      shadow_val[j]  = '0;
      shadow_link[j] = PTR_W'(j + 1);
    end
    shadow_head  = NIL;
    shadow_free  = '0;
    shadow_count = '0;

    add_op(REQ_DUMP, '0, '0);
    add_op(REQ_DEL, 32'd77, '0);
    add_op(REQ_POS, 32'h7fff_ffff, 8'd0);
    add_op(REQ_HEAD, 32'h8000_0000, 8'd0);
    add_op(REQ_TAIL, 32'd0, 8'd255);
    add_op(REQ_POS, 32'hffff_ffff, 8'd1);
    add_op(REQ_POS, 32'd5, 8'd0);
    add_op(REQ_POS, 32'd6, 8'd5);
    add_op(REQ_POS, 32'h55aa_55aa, 8'd4);
    add_op(REQ_POS, 32'd8, 8'd255);
    add_op(REQ_DEL, 32'h8000_0000, '0);
    add_op(REQ_DEL, 32'd12345, '0);
    add_op(REQ_SPARE_LO, 32'hffff_ffff, 8'hff);
    for (j = 0; j < 12; j++) add_op(REQ_HEAD, 32'(j * 1000 + 7), '0);
    add_op(REQ_HEAD, 32'd1, '0);
    add_op(REQ_TAIL, 32'd2, '0);
    add_op(REQ_POS, 32'd3, 8'd3);
    add_op(REQ_DUMP, '0, '0);
    add_op(REQ_DEL, 32'd0, '0);
    add_op(REQ_DEL, 32'(11 * 1000 + 7), '0);

    // random runs that grow, shrink or churn the list
    for (c = 0; c < 9; c++) begin
      mode = $urandom_range(0, 2);
      ins_w = (mode == 0) ? 70 : (mode == 1) ? 25 : 45;
      del_w = (mode == 0) ? 15 : (mode == 1) ? 60 : 35;
      for (j = 0; j < 8; j++)
        pool[j] = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 3)) : $urandom;
      for (j = 0; j < 25; j++) begin
        r = $urandom_range(0, 99);
        v = ($urandom_range(0, 9) < 7) ? pool[$urandom_range(0, 7)] : $urandom;
        p = ($urandom_range(0, 4) != 0) ? POS_W'($urandom_range(0, 17))
                                        : POS_W'($urandom_range(0, 255));
        if (r < ins_w) begin
          case ($urandom_range(0, 2))
            0: kind = REQ_HEAD;
            1: kind = REQ_TAIL;
            default: kind = REQ_POS;
          endcase
        end else if (r < ins_w + del_w) begin
          kind = REQ_DEL;
          if ($urandom_range(0, 19) != 0) v = pool[$urandom_range(0, 7)];
        end else if (r < 95) begin
          kind = REQ_DUMP;
        end else begin
          kind = TYPE_W'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
        end
        add_op(kind, v, p);
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (list_ops_q.size() != 0 || req_valid) @(negedge clk);
    while (list_results_q.size() != 0) @(negedge clk);
    repeat (40) @(posedge clk);
    if (list_results_q.size() != 0) fail_cnt++;

    if (fail_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ bounded_linked_list_engine.f @@
rtl/bll_pkg.sv
rtl/bll_mem.sv
rtl/bll_ctrl.sv
rtl/bounded_linked_list_engine.sv
rtl/bll_chk.sv
tb/sv/tb_bounded_linked_list_engine.sv
